// ===== rtl/core/sbc_pkg.sv =====
// Shared types and constants for the single-board computer system bus.
`timescale 1ns / 1ps

package sbc_pkg;

    // Bus request kinds on the input tuser
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Address map
    localparam logic [15:0] WIN_MASK   = 16'hFC00;
    localparam logic [15:0] IO_FIRST   = 16'hC000;
    localparam logic [15:0] IO_LAST    = 16'hCFFF;
    localparam logic [15:0] WIN_KEYS   = 16'hC000;
    localparam logic [15:0] WIN_SCREEN = 16'hC400;
    localparam logic [15:0] WIN_NMIACK = 16'hC800;
    localparam logic [15:0] WIN_GPIO   = 16'hCC00;
    localparam logic [15:0] ROM_BASE   = 16'hE000;

    // Read values and screen geometry
    localparam logic [7:0] OPEN_BUS     = 8'hFF;
    localparam logic [7:0] GPIO_IDLE    = 8'hF1;
    localparam logic [3:0] SCREEN_DIGITS = 4'd12;
    localparam logic [3:0] SCREEN_LAST   = 4'd11;

    // Field widths
    localparam int unsigned KEY_W      = 48;
    localparam int unsigned CFG_W      = 14;
    localparam int unsigned IN_DATA_W  = 80;
    localparam int unsigned OUT_DATA_W = 32;

    // Reset value of the RAM byte count register
    localparam logic [CFG_W-1:0] RAM_BYTES_RST = 14'd8192;

    // Classified request kinds passed from front to back
    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_RAM_RD   = 4'd1;
    localparam logic [3:0] CMD_RAM_WR   = 4'd2;
    localparam logic [3:0] CMD_ROM_RD   = 4'd3;
    localparam logic [3:0] CMD_ROM_WR   = 4'd4;
    localparam logic [3:0] CMD_CONST_RD = 4'd5;
    localparam logic [3:0] CMD_NMI_RD   = 4'd6;
    localparam logic [3:0] CMD_NMI_WR   = 4'd7;
    localparam logic [3:0] CMD_GPIO_RD  = 4'd8;
    localparam logic [3:0] CMD_GPIO_WR  = 4'd9;
    localparam logic [3:0] CMD_SCREEN   = 4'd10;
    localparam logic [3:0] CMD_TICK     = 4'd11;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        esda;
        logic        escl;
        logic [3:0]  spos;
    } t_cmd;

    typedef struct packed {
        logic [7:0] screen_char;
        logic [3:0] screen_position;
        logic       screen_write;
        logic       nmi_fire;
        logic       rom_protect;
        logic       scl_drive;
        logic       sda_drive;
        logic [7:0] read_data;
    } t_result;

endpackage

// ===== rtl/core/sbc_bus_decoder_with_io.sv =====
// Top level of the single-board computer system bus with I/O windows.
`timescale 1ns / 1ps

// Usage:
// Each request on the s_axis channel is one CPU bus access (tuser 0 read,
// 1 write) or an NMI timer tick (tuser 2); it yields exactly one result on
// m_axis with the read byte, the GPIO line and ROM protect levels after the
// request, the NMI fire flag and any display digit update.
// The RAM size register is written through i_cfg_valid/i_cfg_data and is
// always ready; write it only while no request is in flight.
// An accepted request passes the queue stage, the memory read stage and the
// output register on its way to m_axis.
// Throughput: one request per cycle while results are taken; the RAM and ROM
// single ports serve at most one access per request, so the back end keeps up.
// A stalled receiver holds the output register; the two-entry queue and the
// read stage fill and then s_axis_tready drops until results are taken.
// Reset (i_rst_n low at a clock edge) empties the pipeline, sets RAM size to
// 8192, ROM protect and NMI pending to 1 and both GPIO drives to 0. RAM and
// ROM contents are not cleared and read undefined until written.
module sbc_bus_decoder_with_io
    import sbc_pkg::*;
#(
    parameter int unsigned RAM_DEPTH = 8192,
    parameter int unsigned ROM_DEPTH = 8192,
    parameter int unsigned KEY_ROWS  = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Bus request channel
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: address[15:0], write_data[23:16], key_matrix[71:24],
    //        eeprom_sda[72], eeprom_scl[73], zero[79:74]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: mode[1:0]
    input  logic [1:0]            s_axis_tuser,
    // RAM size register write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // Result channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: read_data[7:0], sda_drive[8], scl_drive[9], rom_protect[10],
    //        nmi_fire[11], screen_write[12], screen_position[16:13],
    //        screen_char[24:17], zero[31:25]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic q_ready;
    logic q_valid;
    logic push;
    logic pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    sbc_front #(
        .RAM_DEPTH (RAM_DEPTH),
        .ROM_DEPTH (ROM_DEPTH),
        .KEY_ROWS  (KEY_ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_q_ready     (q_ready),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    sbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    sbc_back #(
        .RAM_DEPTH (RAM_DEPTH),
        .ROM_DEPTH (ROM_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/sbc_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module sbc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/sbc_front.sv =====
// Front end: accepts bus requests, decodes the address map and classifies them.
`timescale 1ns / 1ps

module sbc_front
    import sbc_pkg::*;
#(
    parameter int unsigned RAM_DEPTH = 8192,
    parameter int unsigned ROM_DEPTH = 8192,
    parameter int unsigned KEY_ROWS  = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    localparam logic [CFG_W-1:0] RAM_LIM_MAX = CFG_W'(RAM_DEPTH);
    localparam logic [16:0]      ROM_SPAN    = 17'(ROM_DEPTH);

    logic [CFG_W-1:0] r_ram_bytes;

    logic [1:0]       mode;
    logic [15:0]      addr;
    logic [7:0]       wdata;
    logic [63:0]      keys;
    logic             esda;
    logic             escl;
    logic [CFG_W-1:0] ram_lim;
    logic [15:0]      rom_off;
    logic             in_ram;
    logic             in_rom;
    logic             in_io;
    logic [15:0]      window;
    logic [7:0]       key_val;
    t_cmd             cmd;

    // Unpack the request
    assign mode  = s_axis_tuser;
    assign addr  = s_axis_tdata[15:0];
    assign wdata = s_axis_tdata[23:16];
    assign keys  = {16'd0, s_axis_tdata[71:24]};
    assign esda  = s_axis_tdata[72];
    assign escl  = s_axis_tdata[73];

    // Hold the RAM byte count register; writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_bytes <= RAM_BYTES_RST;
        end else if (i_cfg_valid) begin
            r_ram_bytes <= i_cfg_data;
        end
    end

    // Decode regions
    assign ram_lim = (r_ram_bytes > RAM_LIM_MAX) ? RAM_LIM_MAX : r_ram_bytes;
    assign rom_off = addr - ROM_BASE;
    assign in_ram  = addr < {2'b00, ram_lim};
    assign in_rom  = (addr >= ROM_BASE) && ({1'b0, rom_off} < ROM_SPAN);
    assign in_io   = (addr >= IO_FIRST) && (addr <= IO_LAST);
    assign window  = addr & WIN_MASK;

    // AND in each key row whose address bit is low
    always_comb begin
        key_val = OPEN_BUS;
        for (int i = 0; i < KEY_ROWS; i++) begin
            if (!addr[i]) begin
                key_val = key_val & keys[8*i +: 8];
            end
        end
    end

    // Classify the request
    always_comb begin
        cmd      = '0;
        cmd.kind = CMD_NONE;
        cmd.addr = addr;
        cmd.data = wdata;
        cmd.esda = esda;
        cmd.escl = escl;
        cmd.spos = SCREEN_LAST - addr[3:0];
        case (mode)
            MODE_READ: begin
                if (in_ram) begin
                    cmd.kind = CMD_RAM_RD;
                end else if (in_rom) begin
                    cmd.kind = CMD_ROM_RD;
                end else if (in_io) begin
                    case (window)
                        WIN_KEYS: begin
                            cmd.kind = CMD_CONST_RD;
                            cmd.data = key_val;
                        end
                        WIN_NMIACK: cmd.kind = CMD_NMI_RD;
                        WIN_GPIO:   cmd.kind = CMD_GPIO_RD;
                        default: begin
                            cmd.kind = CMD_CONST_RD;
                            cmd.data = OPEN_BUS;
                        end
                    endcase
                end else begin
                    cmd.kind = CMD_CONST_RD;
                    cmd.data = OPEN_BUS;
                end
            end
            MODE_WRITE: begin
                if (in_ram) begin
                    cmd.kind = CMD_RAM_WR;
                end else if (in_rom) begin
                    cmd.kind = CMD_ROM_WR;
                end else if (in_io) begin
                    case (window)
                        WIN_SCREEN: begin
                            if (addr[3:0] < SCREEN_DIGITS) begin
                                cmd.kind = CMD_SCREEN;
                            end
                        end
                        WIN_NMIACK: cmd.kind = CMD_NMI_WR;
                        WIN_GPIO:   cmd.kind = CMD_GPIO_WR;
                        default:    cmd.kind = CMD_NONE;
                    endcase
                end
            end
            MODE_TICK: cmd.kind = CMD_TICK;
            default:   cmd.kind = CMD_NONE;
        endcase
    end

    assign s_axis_tready = i_q_ready;
    assign o_push        = s_axis_tvalid && i_q_ready;
    assign o_cmd         = cmd;

endmodule

// ===== rtl/core/sbc_queue.sv =====
// Two-entry request queue between the front and back ends.
`timescale 1ns / 1ps

module sbc_queue
    import sbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_ent[r_rp];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/sbc_back.sv =====
// Back end: executes requests against RAM, ROM and I/O state, delivers results.
`timescale 1ns / 1ps

module sbc_back
    import sbc_pkg::*;
#(
    parameter int unsigned RAM_DEPTH = 8192,
    parameter int unsigned ROM_DEPTH = 8192
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int unsigned RAM_AW = $clog2(RAM_DEPTH);
    localparam int unsigned ROM_AW = $clog2(ROM_DEPTH);

    // Architectural I/O state
    logic r_prot;
    logic r_nmi;
    logic r_sda;
    logic r_scl;
    logic n_prot;
    logic n_nmi;
    logic n_sda;
    logic n_scl;

    // Execute results
    t_result part;
    logic    ram_we;
    logic    ram_re;
    logic    rom_we;
    logic    rom_re;
    logic    pop;
    logic    out_free;
    logic    mid_free;

    // Read-data stage
    logic    r_mid_valid;
    t_result r_mid;
    logic    r_mid_ram;
    logic    r_mid_rom;
    t_result merged;

    // Output register
    logic    r_out_valid;
    t_result r_out;

    logic [7:0] ram_q;
    logic [7:0] rom_q;

    assign out_free = !r_out_valid || m_axis_tready;
    assign mid_free = !r_mid_valid || out_free;
    assign pop      = i_q_valid && mid_free;
    assign o_pop    = pop;

    // Execute the request at the queue head
    always_comb begin
        n_prot = r_prot;
        n_nmi  = r_nmi;
        n_sda  = r_sda;
        n_scl  = r_scl;
        ram_we = 1'b0;
        ram_re = 1'b0;
        rom_we = 1'b0;
        rom_re = 1'b0;
        part   = '0;
        case (i_cmd.kind)
            CMD_RAM_RD: ram_re = pop;
            CMD_RAM_WR: ram_we = pop;
            CMD_ROM_RD: rom_re = pop;
            CMD_ROM_WR: rom_we = pop && !r_prot;
            CMD_CONST_RD: part.read_data = i_cmd.data;
            CMD_NMI_RD: begin
                part.read_data = OPEN_BUS;
                n_nmi          = 1'b0;
            end
            CMD_NMI_WR: n_nmi = 1'b0;
            CMD_GPIO_RD: begin
                part.read_data = GPIO_IDLE
                               | {4'd0, r_prot, i_cmd.escl & r_scl, i_cmd.esda & r_sda, 1'b0};
            end
            CMD_GPIO_WR: begin
                n_sda  = i_cmd.data[1];
                n_scl  = i_cmd.data[2];
                n_prot = i_cmd.data[3];
            end
            CMD_SCREEN: begin
                part.screen_write    = 1'b1;
                part.screen_position = i_cmd.spos;
                part.screen_char     = i_cmd.data;
            end
            CMD_TICK: begin
                if (!r_nmi) begin
                    part.nmi_fire = 1'b1;
                    n_nmi         = 1'b1;
                end
            end
            default: part = '0;
        endcase
        part.sda_drive   = n_sda;
        part.scl_drive   = n_scl;
        part.rom_protect = n_prot;
    end

    // Update I/O state when a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prot <= 1'b1;
            r_nmi  <= 1'b1;
            r_sda  <= 1'b0;
            r_scl  <= 1'b0;
        end else if (pop) begin
            r_prot <= n_prot;
            r_nmi  <= n_nmi;
            r_sda  <= n_sda;
            r_scl  <= n_scl;
        end
    end

    sbc_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (i_cmd.addr[RAM_AW-1:0]),
        .i_wdata (i_cmd.data),
        .o_rdata (ram_q)
    );

    sbc_ram #(
        .WIDTH (8),
        .DEPTH (ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (rom_we),
        .i_re    (rom_re),
        .i_addr  (i_cmd.addr[ROM_AW-1:0]),
        .i_wdata (i_cmd.data),
        .o_rdata (rom_q)
    );

    // Hold the executed result while memory read data arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_free) begin
            r_mid_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_mid     <= part;
            r_mid_ram <= (i_cmd.kind == CMD_RAM_RD);
            r_mid_rom <= (i_cmd.kind == CMD_ROM_RD);
        end
    end

    // Merge memory read data
    always_comb begin
        merged = r_mid;
        if (r_mid_ram) begin
            merged.read_data = ram_q;
        end else if (r_mid_rom) begin
            merged.read_data = rom_q;
        end
    end

    // Output register: advance when the receiver takes the result or the slot is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_mid_valid) begin
            r_out <= merged;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

endmodule

// ===== dv/tb_sbc_bus_decoder_with_io.sv =====
// Self-checking testbench for the single-board computer system bus decoder.
`timescale 1ns / 1ps

module tb_sbc_bus_decoder_with_io;
    import sbc_pkg::*;

    localparam int unsigned RAM_DEPTH_C  = 8192;
    localparam int unsigned ROM_DEPTH_C  = 8192;
    localparam int unsigned KEY_ROWS_C   = 6;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PHASE_ITEMS  = 165;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;

    // Bus-level predictor: tracks memories, GPIO, NMI pending and the RAM byte count
    class sbc_bus_predictor;
        int unsigned ram_bytes;
        bit          rom_protect;
        bit          nmi_pending;
        bit          sda_bit;
        bit          scl_bit;
        logic [7:0]  ram_mem [int];
        logic [7:0]  rom_mem [int];
        int unsigned ram_addrs [$];
        int unsigned rom_addrs [$];
        t_result     due_results [$];
        int unsigned errors;
        int unsigned n_reads;
        int unsigned n_writes;
        int unsigned n_ticks;
        int unsigned n_fires;
        int unsigned n_digits;

        function new();
            ram_bytes   = RAM_BYTES_RST;
            rom_protect = 1'b1;
            nmi_pending = 1'b1;
            sda_bit     = 1'b0;
            scl_bit     = 1'b0;
        endfunction

        function int unsigned ram_limit();
            return (ram_bytes > RAM_DEPTH_C) ? RAM_DEPTH_C : ram_bytes;
        endfunction

        // A read is safe unless it hits a RAM or ROM byte never written
        function bit read_is_defined(logic [15:0] addr);
            if (addr < ram_limit())
                return ram_mem.exists(int'(addr));
            if (addr >= ROM_BASE)
                return rom_mem.exists(int'(addr - ROM_BASE));
            return 1'b1;
        endfunction

        function logic [7:0] key_scan(logic [15:0] addr, logic [KEY_W-1:0] keys);
            logic [7:0] rows;
            int         r;
            rows = OPEN_BUS;
            for (r = 0; r < KEY_ROWS_C; r++) begin
                if (!addr[r])
                    rows &= keys[8*r +: 8];
            end
            return rows;
        endfunction

        // Work out the result of one accepted request and queue it
        function void note_access(logic [1:0] mode, logic [15:0] addr, logic [7:0] wdata,
                                  logic [KEY_W-1:0] keys, logic esda, logic escl);
            t_result     res;
            int unsigned lim;
            res = '0;
            lim = ram_limit();
            if (mode == MODE_READ) begin
                n_reads++;
                if (addr < lim) begin
                    res.read_data = ram_mem.exists(int'(addr)) ? ram_mem[int'(addr)] : 8'h00;
                end else if (addr >= ROM_BASE) begin
                    res.read_data = rom_mem.exists(int'(addr - ROM_BASE)) ?
                                    rom_mem[int'(addr - ROM_BASE)] : 8'h00;
                end else if (addr >= IO_FIRST && addr <= IO_LAST) begin
                    case (addr & WIN_MASK)
                        WIN_KEYS: res.read_data = key_scan(addr, keys);
                        WIN_NMIACK: begin
                            nmi_pending   = 1'b0;
                            res.read_data = OPEN_BUS;
                        end
                        WIN_GPIO: res.read_data = GPIO_IDLE | {4'b0, rom_protect,
                                                  escl & scl_bit, esda & sda_bit, 1'b0};
                        default: res.read_data = OPEN_BUS;
                    endcase
                end else begin
                    res.read_data = OPEN_BUS;
                end
            end else if (mode == MODE_WRITE) begin
                n_writes++;
                if (addr < lim) begin
                    if (!ram_mem.exists(int'(addr)))
                        ram_addrs.push_back(addr);
                    ram_mem[int'(addr)] = wdata;
                end else if (addr >= ROM_BASE) begin
                    if (!rom_protect) begin
                        if (!rom_mem.exists(int'(addr - ROM_BASE)))
                            rom_addrs.push_back(addr - ROM_BASE);
                        rom_mem[int'(addr - ROM_BASE)] = wdata;
                    end
                end else if (addr >= IO_FIRST && addr <= IO_LAST) begin
                    case (addr & WIN_MASK)
                        WIN_SCREEN: begin
                            if (addr[3:0] < SCREEN_DIGITS) begin
                                res.screen_write    = 1'b1;
                                res.screen_position = SCREEN_LAST - addr[3:0];
                                res.screen_char     = wdata;
                                n_digits++;
                            end
                        end
                        WIN_NMIACK: nmi_pending = 1'b0;
                        WIN_GPIO: begin
                            sda_bit     = wdata[1];
                            scl_bit     = wdata[2];
                            rom_protect = wdata[3];
                        end
                        default: ;
                    endcase
                end
            end else if (mode == MODE_TICK) begin
                n_ticks++;
                if (!nmi_pending) begin
                    res.nmi_fire = 1'b1;
                    nmi_pending  = 1'b1;
                    n_fires++;
                end
            end
            res.sda_drive   = sda_bit;
            res.scl_drive   = scl_bit;
            res.rom_protect = rom_protect;
            due_results.push_back(res);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                errors++;
                $display("%0t: %s mismatch: expected 'h%0h, actual 'h%0h",
                         $time, name, want, seen);
            end
        endfunction

        // Match one delivered result against the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] tdata);
            t_result got;
            t_result want;
            got = t_result'(tdata[$bits(t_result)-1:0]);
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result 'h%0h with none expected", $time, tdata);
                return;
            end
            want = due_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("sda_drive", want.sda_drive, got.sda_drive);
            compare_field("scl_drive", want.scl_drive, got.scl_drive);
            compare_field("rom_protect", want.rom_protect, got.rom_protect);
            compare_field("nmi_fire", want.nmi_fire, got.nmi_fire);
            compare_field("screen_write", want.screen_write, got.screen_write);
            compare_field("screen_position", want.screen_position, got.screen_position);
            compare_field("screen_char", want.screen_char, got.screen_char);
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = MODE_READ;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data    = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    sbc_bus_predictor pred;
    int unsigned      cycle_count = 0;
    int unsigned      stall_left  = 0;
    int unsigned      stall_style = 0;
    int unsigned      phase_size [7];

    sbc_bus_decoder_with_io #(
        .RAM_DEPTH (RAM_DEPTH_C),
        .ROM_DEPTH (ROM_DEPTH_C),
        .KEY_ROWS  (KEY_ROWS_C)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sbc_bus_decoder_with_io regression: fail");
            $finish;
        end
    end

    // Receiver: switch at random among four tready patterns, each kept until stall_left runs out
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_left  <= $urandom_range(32, 256);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ((stall_left % 16) < 10);
        endcase
    end

    // Check every delivered result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            pred.check_result(m_axis_tdata);
    end

    // Present one request and hold it until accepted; tvalid stays high afterwards
    task automatic push_access(logic [1:0] mode, logic [15:0] addr, logic [7:0] wdata,
                               logic [KEY_W-1:0] keys, logic esda, logic escl);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {6'b0, escl, esda, keys, wdata, addr};
        do @(posedge i_clk); while (!s_axis_tready);
        pred.note_access(mode, addr, wdata, keys, esda, escl);
    endtask

    task automatic hold_off(int unsigned cycles);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait until every queued result is out
    task automatic drain_pipeline();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pred.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ram_bytes(logic [CFG_W-1:0] size);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        do @(posedge i_clk); while (!o_cfg_ready);
        pred.ram_bytes = size;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] rand_keys();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return KEY_W'({$urandom, $urandom});
        endcase
    endfunction

    // Keep reads off unwritten memory: fall back to the unmapped hole
    function automatic logic [15:0] settle_read_addr(logic [15:0] addr);
        if (pred.read_is_defined(addr))
            return addr;
        return 16'hD000 | 16'($urandom_range(0, 16'h0FFF));
    endfunction

    function automatic logic [15:0] recall_addr();
        int unsigned which;
        which = $urandom_range(0, 2);
        if (which == 0 && pred.ram_addrs.size() != 0)
            return 16'(pred.ram_addrs[$urandom_range(0, pred.ram_addrs.size() - 1)]);
        if (which == 1 && pred.rom_addrs.size() != 0)
            return ROM_BASE
                   + 16'(pred.rom_addrs[$urandom_range(0, pred.rom_addrs.size() - 1)]);
        return settle_read_addr(16'($urandom_range(0, 16'hFFFF)));
    endfunction

    task automatic random_access();
        logic [1:0]  mode;
        logic [15:0] addr;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        mode = MODE_READ;
        if (pick < 18) begin
            mode = MODE_WRITE;
            addr = $urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                        : 16'($urandom_range(0, 16'h1FFF));
        end else if (pick < 38) begin
            addr = recall_addr();
        end else if (pick < 46) begin
            mode = MODE_WRITE;
            addr = ROM_BASE | ($urandom_range(0, 1) ? 16'($urandom_range(0, 63))
                                                     : 16'($urandom_range(0, 16'h1FFF)));
        end else if (pick < 54) begin
            mode = MODE_WRITE;
            addr = WIN_GPIO | 16'($urandom_range(0, 16'h03FF));
        end else if (pick < 60) begin
            addr = WIN_GPIO | 16'($urandom_range(0, 16'h03FF));
        end else if (pick < 67) begin
            addr = WIN_KEYS | 16'($urandom_range(0, 16'h03FF));
        end else if (pick < 75) begin
            mode = MODE_WRITE;
            addr = WIN_SCREEN | 16'($urandom_range(0, 16'h03FF));
        end else if (pick < 81) begin
            mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
            addr = WIN_NMIACK | 16'($urandom_range(0, 16'h03FF));
        end else if (pick < 90) begin
            mode = MODE_TICK;
            addr = 16'($urandom_range(0, 16'hFFFF));
        end else if (pick < 92) begin
            mode = MODE_UNUSED;
            addr = 16'($urandom_range(0, 16'hFFFF));
        end else begin
            // noise: any mode anywhere
            mode = 2'($urandom_range(0, 3));
            addr = 16'($urandom_range(0, 16'hFFFF));
            if (mode == MODE_READ)
                addr = settle_read_addr(addr);
        end
        push_access(mode, addr, 8'($urandom_range(0, 255)), rand_keys(),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Send a run of random requests in bursts with random gaps
    task automatic random_phase(int unsigned count);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            while (burst != 0 && sent < count) begin
                random_access();
                sent++;
                burst--;
            end
            gap = $urandom_range(0, 6);
            if (gap != 0)
                hold_off(gap);
        end
    endtask

    task automatic directed_accesses();
        // GPIO state and NMI handshake out of reset
        push_access(MODE_READ,  WIN_GPIO,   8'h00, '1, 1'b1, 1'b1);
        push_access(MODE_TICK,  16'h0000,   8'h00, '1, 1'b0, 1'b0);
        push_access(MODE_READ,  WIN_NMIACK, 8'h00, '1, 1'b0, 1'b0);
        push_access(MODE_TICK,  16'hFFFF,   8'hFF, '1, 1'b1, 1'b1);
        push_access(MODE_TICK,  16'h0000,   8'h00, '0, 1'b0, 1'b0);
        push_access(MODE_WRITE, 16'hCBFF,   8'hFF, '0, 1'b1, 1'b1);
        push_access(MODE_TICK,  16'h1234,   8'h00, '0, 1'b0, 1'b0);
        // RAM at both ends
        push_access(MODE_WRITE, 16'h0000,   8'h00, '0, 1'b0, 1'b0);
        push_access(MODE_WRITE, 16'h1FFF,   8'hFF, '1, 1'b1, 1'b1);
        push_access(MODE_READ,  16'h0000,   8'h00, '1, 1'b0, 1'b0);
        push_access(MODE_READ,  16'h1FFF,   8'h00, '0, 1'b0, 1'b0);
        // ROM: blocked while protected, then unprotect, write, read back, protect
        push_access(MODE_WRITE, ROM_BASE,   8'hAA, '0, 1'b0, 1'b0);
        push_access(MODE_WRITE, 16'hCFFF,   8'h06, '0, 1'b0, 1'b1);
        push_access(MODE_READ,  16'hCC55,   8'h00, '0, 1'b0, 1'b1);
        push_access(MODE_WRITE, ROM_BASE,   8'h5A, '0, 1'b1, 1'b0);
        push_access(MODE_WRITE, 16'hFFFF,   8'hA5, '0, 1'b1, 1'b1);
        push_access(MODE_READ,  16'hFFFF,   8'h00, '0, 1'b1, 1'b1);
        push_access(MODE_WRITE, WIN_GPIO,   8'hF9, '0, 1'b1, 1'b1);
        // keyboard: all rows, no rows, some rows
        push_access(MODE_READ,  WIN_KEYS,   8'h00, 48'hFE7F_BFDF_EFF7, 1'b0, 1'b0);
        push_access(MODE_READ,  16'hC03F,   8'h00, '0, 1'b0, 1'b0);
        push_access(MODE_READ,  16'hC3D5,   8'h00, 48'h0123_4567_89AB, 1'b0, 1'b0);
        // screen: first and last digit, offsets past the digits
        push_access(MODE_WRITE, WIN_SCREEN, 8'h41, '0, 1'b0, 1'b0);
        push_access(MODE_WRITE, 16'hC40B,   8'hFF, '0, 1'b0, 1'b0);
        push_access(MODE_WRITE, 16'hC40C,   8'h55, '0, 1'b0, 1'b0);
        push_access(MODE_WRITE, 16'hC7FF,   8'h33, '0, 1'b0, 1'b0);
        // unmapped reads and the unused mode
        push_access(MODE_READ,  16'h2000,   8'h00, '0, 1'b0, 1'b0);
        push_access(MODE_READ,  16'hDFFF,   8'h00, '0, 1'b0, 1'b0);
        push_access(MODE_UNUSED, 16'h0000,  8'h77, '0, 1'b1, 1'b1);
    endtask

    initial begin
        pred = new();
        phase_size = '{8192, 0, 1, 16383, $urandom_range(2, 8191), 256,
                       $urandom_range(8193, 16382)};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_accesses();
        drain_pipeline();
        foreach (phase_size[p]) begin
            set_ram_bytes(CFG_W'(phase_size[p]));
            random_phase(PHASE_ITEMS);
            drain_pipeline();
        end
        repeat (8) @(posedge i_clk);

        $display("Covered %0d reads, %0d writes, %0d ticks (%0d NMIs fired), %0d digit updates",
                 pred.n_reads, pred.n_writes, pred.n_ticks, pred.n_fires, pred.n_digits);
        $display("RAM sizes from 0 to 16383 across %0d phases; %0d RAM and %0d ROM bytes written",
                 $size(phase_size), pred.ram_addrs.size(), pred.rom_addrs.size());
        if (pred.errors == 0)
            $display("sbc_bus_decoder_with_io regression: pass");
        else
            $display("sbc_bus_decoder_with_io regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sbc_pkg.sv
rtl/core/sbc_ram.sv
rtl/core/sbc_front.sv
rtl/core/sbc_queue.sv
rtl/core/sbc_back.sv
rtl/core/sbc_bus_decoder_with_io.sv
dv/tb_sbc_bus_decoder_with_io.sv
